/* design/ccis_pkg.sv */
package ccis_pkg;

    // Default coordinate width in bits (Q16.16 signed values).
    localparam int COORD_WIDTH_DEF = 32;

endpackage

/* design/ccis_sqrt_cell.sv */
module ccis_sqrt_cell #(
    parameter int RADW  = 66,
    parameter int ROOTW = 33,
    parameter int PW    = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [RADW-1:0]  in_rad,
    input  logic [ROOTW-1:0] in_root,
    input  logic [ROOTW+1:0] in_rem,
    input  logic [PW-1:0]    in_pay,
    output logic             out_valid,
    output logic [RADW-1:0]  out_rad,
    output logic [ROOTW-1:0] out_root,
    output logic [ROOTW+1:0] out_rem,
    output logic [PW-1:0]    out_pay
);

    logic [ROOTW+3:0] acc;
    logic [ROOTW+3:0] trial;
    logic             take;
    logic [ROOTW+3:0] diff;

    // One root bit: bring down two radicand bits and try (4*root + 1).
    assign acc   = {in_rem, in_rad[RADW-1:RADW-2]};
    assign trial = {2'b00, in_root, 2'b01};
    assign take  = (acc >= trial);
    assign diff  = acc - trial;

    // The valid bit is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= in_valid;
        end
    end

    // Data moves to the next cell every cycle.
    always_ff @(posedge clk)
    begin
        out_rad  <= {in_rad[RADW-3:0], 2'b00};
        out_root <= {in_root[ROOTW-2:0], take};
        out_rem  <= take ? diff[ROOTW+1:0] : acc[ROOTW+1:0];
        out_pay  <= in_pay;
    end

endmodule

/* design/ccis_sqrt_chain.sv */
module ccis_sqrt_chain #(
    parameter int RADW = 66,
    parameter int PW   = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [RADW-1:0]     in_rad,
    input  logic [PW-1:0]       in_pay,
    output logic                out_valid,
    output logic [RADW/2-1:0]   out_root,
    output logic [RADW/2+1:0]   out_rem,
    output logic [PW-1:0]       out_pay
);

    localparam int ROOTW = RADW / 2;

    logic             v    [0:ROOTW];
    logic [RADW-1:0]  rad  [0:ROOTW];
    logic [ROOTW-1:0] root [0:ROOTW];
    logic [ROOTW+1:0] rem  [0:ROOTW];
    logic [PW-1:0]    pay  [0:ROOTW];

    // Head of the row: an empty root and remainder.
    assign v[0]    = in_valid;
    assign rad[0]  = in_rad;
    assign root[0] = '0;
    assign rem[0]  = '0;
    assign pay[0]  = in_pay;

    // One cell per root bit, most significant first.
    for (genvar i = 0; i < ROOTW; i++)
    begin : g_cell
        ccis_sqrt_cell #(
            .RADW  (RADW),
            .ROOTW (ROOTW),
            .PW    (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[i]),
            .in_rad    (rad[i]),
            .in_root   (root[i]),
            .in_rem    (rem[i]),
            .in_pay    (pay[i]),
            .out_valid (v[i+1]),
            .out_rad   (rad[i+1]),
            .out_root  (root[i+1]),
            .out_rem   (rem[i+1]),
            .out_pay   (pay[i+1])
        );
    end

    assign out_valid = v[ROOTW];
    assign out_root  = root[ROOTW];
    assign out_rem   = rem[ROOTW];
    assign out_pay   = pay[ROOTW];

endmodule

/* design/ccis_div_cell.sv */
module ccis_div_cell #(
    parameter int NW = 66,
    parameter int DW = 34,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [NW-1:0] in_quo,
    input  logic [DW-1:0] in_rem,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [NW-1:0] out_num,
    output logic [DW-1:0] out_div,
    output logic [NW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [PW-1:0] out_pay
);

    logic [DW:0] acc;
    logic [DW:0] diff;
    logic        take;

    // One quotient bit: shift in the next numerator bit and try a subtract.
    assign acc  = {in_rem, in_num[NW-1]};
    assign diff = acc - {1'b0, in_div};
    assign take = (acc >= {1'b0, in_div});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_num <= {in_num[NW-2:0], 1'b0};
        out_div <= in_div;
        out_quo <= {in_quo[NW-2:0], take};
        out_rem <= take ? diff[DW-1:0] : acc[DW-1:0];
        out_pay <= in_pay;
    end

endmodule

/* design/ccis_div_chain.sv */
module ccis_div_chain #(
    parameter int NW = 66,
    parameter int DW = 34,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);

    logic          v   [0:NW];
    logic [NW-1:0] num [0:NW];
    logic [DW-1:0] dvs [0:NW];
    logic [NW-1:0] quo [0:NW];
    logic [DW-1:0] rem [0:NW];
    logic [PW-1:0] pay [0:NW];

    assign v[0]   = in_valid;
    assign num[0] = in_num;
    assign dvs[0] = in_div;
    assign quo[0] = '0;
    assign rem[0] = '0;
    assign pay[0] = in_pay;

    // One cell per quotient bit, restoring division.
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        ccis_div_cell #(
            .NW (NW),
            .DW (DW),
            .PW (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[i]),
            .in_num    (num[i]),
            .in_div    (dvs[i]),
            .in_quo    (quo[i]),
            .in_rem    (rem[i]),
            .in_pay    (pay[i]),
            .out_valid (v[i+1]),
            .out_num   (num[i+1]),
            .out_div   (dvs[i+1]),
            .out_quo   (quo[i+1]),
            .out_rem   (rem[i+1]),
            .out_pay   (pay[i+1])
        );
    end

    assign out_valid = v[NW];
    assign out_quo   = quo[NW];
    assign out_pay   = pay[NW];

endmodule

/* design/circle_circle_intersection.sv */
// Two-circle intersection. An item is taken when start is high and busy is
// low; busy rises for one cycle after each accepted item, so items cannot
// enter back to back. Each item gives zero, one or two points on point_valid,
// which is high for exactly one cycle per point; the receiver cannot stall
// and must take every point as it appears. When an item gives two points,
// the second follows the first in the next cycle with last_point high. The
// datapath holds four rows of one-bit cells: the square root of the center
// distance, the division that places the chord, the square root of the
// half-chord and the final divisions by the distance.
module circle_circle_intersection #(
    parameter int COORD_WIDTH = ccis_pkg::COORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] center_a_x,
    input  logic [COORD_WIDTH-1:0] center_a_y,
    input  logic [COORD_WIDTH-1:0] center_b_x,
    input  logic [COORD_WIDTH-1:0] center_b_y,
    input  logic [COORD_WIDTH-2:0] radius_a,
    input  logic [COORD_WIDTH-2:0] radius_b,
    output logic                   point_valid,
    output logic [COORD_WIDTH-1:0] point_x,
    output logic [COORD_WIDTH-1:0] point_y,
    output logic                   last_point
);

    import ccis_pkg::*;

    localparam int W = COORD_WIDTH;

    // Magnitude of a signed numerator, known to stay below 2^(2W).
    function automatic logic [2*W:0] mag_of(input logic signed [2*W+1:0] v);
        logic signed [2*W+1:0] t;
        t = v[2*W+1] ? -v : v;
        return t[2*W:0];
    endfunction

    // Center plus or minus a quotient, saturated to the coordinate range.
    function automatic logic [W-1:0] place(input logic [W-1:0] c,
                                           input logic [2*W:0] q,
                                           input logic neg);
        logic signed [2*W+2:0] ce;
        logic signed [2*W+2:0] qe;
        logic signed [2*W+2:0] s;
        logic [W-1:0]          r;
        ce = $signed({{(W+3){c[W-1]}}, c});
        qe = $signed({2'b00, q});
        s  = neg ? ce - qe : ce + qe;
        if (s[2*W+2:W-1] == '0 || s[2*W+2:W-1] == '1)
        begin
            r = s[W-1:0];
        end
        else if (s[2*W+2])
        begin
            r = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    logic accept;
    logic busy_reg;
    logic busy_next;

    // Items cannot enter back to back.
    assign accept    = start && !busy_reg;
    assign busy_next = accept;
    assign busy      = busy_reg;

    // Stage A: captured item and center difference.
    logic                a_v_reg;
    logic [W-1:0]        a_ax_reg, a_ay_reg;
    logic [W-2:0]        a_ra_reg, a_rb_reg;
    logic signed [W:0]   a_dx_reg, a_dy_reg;

    // Stage B: squares.
    logic                  b_v_reg;
    logic signed [2*W+1:0] b_dx2_reg, b_dy2_reg;
    logic [2*W-3:0]        b_ra2_reg, b_rb2_reg;
    logic [W-1:0]          b_ax_reg, b_ay_reg;
    logic [W-2:0]          b_ra_reg;
    logic signed [W:0]     b_dx_reg, b_dy_reg;
    logic                  b_coin_reg;

    // Stage C: squared distance and difference of squared radii.
    logic                  c_v_reg;
    logic [2*W+1:0]        c_d2_reg;
    logic signed [2*W-2:0] c_diff_reg;
    logic [W-1:0]          c_ax_reg, c_ay_reg;
    logic [W-2:0]          c_ra_reg;
    logic signed [W:0]     c_dx_reg, c_dy_reg;
    logic                  c_coin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            c_v_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            a_v_reg  <= accept;
            b_v_reg  <= a_v_reg;
            c_v_reg  <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_ax_reg <= center_a_x;
            a_ay_reg <= center_a_y;
            a_ra_reg <= radius_a;
            a_rb_reg <= radius_b;
            a_dx_reg <= $signed({center_b_x[W-1], center_b_x})
                      - $signed({center_a_x[W-1], center_a_x});
            a_dy_reg <= $signed({center_b_y[W-1], center_b_y})
                      - $signed({center_a_y[W-1], center_a_y});
        end
        b_dx2_reg  <= (2*W+2)'(a_dx_reg) * (2*W+2)'(a_dx_reg);
        b_dy2_reg  <= (2*W+2)'(a_dy_reg) * (2*W+2)'(a_dy_reg);
        b_ra2_reg  <= (2*W-2)'(a_ra_reg) * (2*W-2)'(a_ra_reg);
        b_rb2_reg  <= (2*W-2)'(a_rb_reg) * (2*W-2)'(a_rb_reg);
        b_ax_reg   <= a_ax_reg;
        b_ay_reg   <= a_ay_reg;
        b_ra_reg   <= a_ra_reg;
        b_dx_reg   <= a_dx_reg;
        b_dy_reg   <= a_dy_reg;
        b_coin_reg <= (a_dx_reg == '0) && (a_dy_reg == '0);

        c_d2_reg   <= $unsigned(b_dx2_reg) + $unsigned(b_dy2_reg);
        c_diff_reg <= $signed({1'b0, b_ra2_reg}) - $signed({1'b0, b_rb2_reg});
        c_ax_reg   <= b_ax_reg;
        c_ay_reg   <= b_ay_reg;
        c_ra_reg   <= b_ra_reg;
        c_dx_reg   <= b_dx_reg;
        c_dy_reg   <= b_dy_reg;
        c_coin_reg <= b_coin_reg;
    end

    // Square root of the squared center distance.
    localparam int P1W = W + W + (W-1) + (W+1) + (W+1) + (2*W-1) + (2*W+2) + 1;

    logic                  s1_v;
    logic [W:0]            s1_root;
    logic [W+2:0]          s1_rem;
    logic [P1W-1:0]        s1_pay;
    logic [W-1:0]          s1_ax, s1_ay;
    logic [W-2:0]          s1_ra;
    logic signed [W:0]     s1_dx, s1_dy;
    logic signed [2*W-2:0] s1_diff;
    logic [2*W+1:0]        s1_d2;
    logic                  s1_coin;

    ccis_sqrt_chain #(
        .RADW (2*W+2),
        .PW   (P1W)
    ) u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_v_reg),
        .in_rad    (c_d2_reg),
        .in_pay    ({c_ax_reg, c_ay_reg, c_ra_reg, c_dx_reg, c_dy_reg,
                     c_diff_reg, c_d2_reg, c_coin_reg}),
        .out_valid (s1_v),
        .out_root  (s1_root),
        .out_rem   (s1_rem),
        .out_pay   (s1_pay)
    );

    assign {s1_ax, s1_ay, s1_ra, s1_dx, s1_dy, s1_diff, s1_d2, s1_coin} = s1_pay;

    // Stage E: distance rounded to nearest and chord numerator.
    logic                  e_v_reg;
    logic [W:0]            e_d_reg;
    logic signed [2*W+2:0] e_num_reg;
    logic [W-1:0]          e_ax_reg, e_ay_reg;
    logic [W-2:0]          e_ra_reg;
    logic signed [W:0]     e_dx_reg, e_dy_reg;
    logic                  e_coin_reg;

    // Stage F: magnitude with half the divisor added for rounding.
    logic                  f_v_reg;
    logic [2*W+1:0]        f_nmag_reg;
    logic [W+1:0]          f_div_reg;
    logic                  f_neg_reg;
    logic [W:0]            f_d_reg;
    logic [W-1:0]          f_ax_reg, f_ay_reg;
    logic [W-2:0]          f_ra_reg;
    logic signed [W:0]     f_dx_reg, f_dy_reg;
    logic                  f_coin_reg;

    logic                  e_round;
    logic [2*W+2:0]        e_num_abs;

    assign e_round   = (s1_rem > {2'b00, s1_root});
    assign e_num_abs = e_num_reg[2*W+2] ? $unsigned(-e_num_reg) : $unsigned(e_num_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
        end
        else
        begin
            e_v_reg <= s1_v;
            f_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_d_reg    <= s1_root + {{W{1'b0}}, e_round};
        e_num_reg  <= $signed({1'b0, s1_d2}) + (2*W+3)'(s1_diff);
        e_ax_reg   <= s1_ax;
        e_ay_reg   <= s1_ay;
        e_ra_reg   <= s1_ra;
        e_dx_reg   <= s1_dx;
        e_dy_reg   <= s1_dy;
        e_coin_reg <= s1_coin;

        f_nmag_reg <= e_num_abs[2*W+1:0] + {{(W+1){1'b0}}, e_d_reg};
        f_div_reg  <= {e_d_reg, 1'b0};
        f_neg_reg  <= e_num_reg[2*W+2];
        f_d_reg    <= e_d_reg;
        f_ax_reg   <= e_ax_reg;
        f_ay_reg   <= e_ay_reg;
        f_ra_reg   <= e_ra_reg;
        f_dx_reg   <= e_dx_reg;
        f_dy_reg   <= e_dy_reg;
        f_coin_reg <= e_coin_reg;
    end

    // Division that places the chord along the center line.
    localparam int P2W = W + W + (W-1) + (W+1) + (W+1) + (W+1) + 1 + 1;

    logic              q1_v;
    logic [2*W+1:0]    q1_quo;
    logic [P2W-1:0]    q1_pay;
    logic [W-1:0]      q1_ax, q1_ay;
    logic [W-2:0]      q1_ra;
    logic signed [W:0] q1_dx, q1_dy;
    logic [W:0]        q1_d;
    logic              q1_neg, q1_coin;

    ccis_div_chain #(
        .NW (2*W+2),
        .DW (W+2),
        .PW (P2W)
    ) u_chord_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_v_reg),
        .in_num    (f_nmag_reg),
        .in_div    (f_div_reg),
        .in_pay    ({f_ax_reg, f_ay_reg, f_ra_reg, f_dx_reg, f_dy_reg, f_d_reg,
                     f_neg_reg, f_coin_reg}),
        .out_valid (q1_v),
        .out_quo   (q1_quo),
        .out_pay   (q1_pay)
    );

    assign {q1_ax, q1_ay, q1_ra, q1_dx, q1_dy, q1_d, q1_neg, q1_coin} = q1_pay;

    // Stages G, H, I: chord offset, its square, and the half-chord squared.
    logic                  g_v_reg, h_v_reg, i_v_reg;
    logic                  g_fail_reg, h_fail_reg, i_fail_reg;
    logic [W-2:0]          g_xm_reg;
    logic signed [W-1:0]   g_x_reg, h_x_reg, i_x_reg;
    logic [W-2:0]          g_ra_reg;
    logic [2*W-3:0]        h_ra2_reg, h_xm2_reg, i_y2_reg;
    logic [W-1:0]          g_ax_reg, g_ay_reg, h_ax_reg, h_ay_reg, i_ax_reg, i_ay_reg;
    logic signed [W:0]     g_dx_reg, g_dy_reg, h_dx_reg, h_dy_reg, i_dx_reg, i_dy_reg;
    logic [W:0]            g_d_reg, h_d_reg, i_d_reg;
    logic [W-1:0]          q1_xm_ext;

    assign q1_xm_ext = {1'b0, q1_quo[W-2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
        end
        else
        begin
            g_v_reg <= q1_v;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g_fail_reg <= q1_coin || (q1_quo > {{(W+3){1'b0}}, q1_ra});
        g_xm_reg   <= q1_quo[W-2:0];
        g_x_reg    <= q1_neg ? $signed(-q1_xm_ext) : $signed(q1_xm_ext);
        g_ra_reg   <= q1_ra;
        g_ax_reg   <= q1_ax;
        g_ay_reg   <= q1_ay;
        g_dx_reg   <= q1_dx;
        g_dy_reg   <= q1_dy;
        g_d_reg    <= q1_d;

        h_ra2_reg  <= (2*W-2)'(g_ra_reg) * (2*W-2)'(g_ra_reg);
        h_xm2_reg  <= (2*W-2)'(g_xm_reg) * (2*W-2)'(g_xm_reg);
        h_fail_reg <= g_fail_reg;
        h_x_reg    <= g_x_reg;
        h_ax_reg   <= g_ax_reg;
        h_ay_reg   <= g_ay_reg;
        h_dx_reg   <= g_dx_reg;
        h_dy_reg   <= g_dy_reg;
        h_d_reg    <= g_d_reg;

        i_y2_reg   <= h_ra2_reg - h_xm2_reg;
        i_fail_reg <= h_fail_reg;
        i_x_reg    <= h_x_reg;
        i_ax_reg   <= h_ax_reg;
        i_ay_reg   <= h_ay_reg;
        i_dx_reg   <= h_dx_reg;
        i_dy_reg   <= h_dy_reg;
        i_d_reg    <= h_d_reg;
    end

    // Square root of the half-chord squared.
    localparam int P3W = W + W + (W+1) + (W+1) + (W+1) + W + 1;

    logic                s2_v;
    logic [W-2:0]        s2_root;
    logic [P3W-1:0]      s2_pay;
    logic [W-1:0]        s2_ax, s2_ay;
    logic signed [W:0]   s2_dx, s2_dy;
    logic [W:0]          s2_d;
    logic signed [W-1:0] s2_x;
    logic                s2_fail;
    logic signed [W-1:0] s2_y;

    ccis_sqrt_chain #(
        .RADW (2*W-2),
        .PW   (P3W)
    ) u_half_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (i_v_reg),
        .in_rad    (i_y2_reg),
        .in_pay    ({i_ax_reg, i_ay_reg, i_dx_reg, i_dy_reg, i_d_reg, i_x_reg,
                     i_fail_reg}),
        .out_valid (s2_v),
        .out_root  (s2_root),
        .out_rem   (),
        .out_pay   (s2_pay)
    );

    assign {s2_ax, s2_ay, s2_dx, s2_dy, s2_d, s2_x, s2_fail} = s2_pay;
    assign s2_y = $signed({1'b0, s2_root});

    // Stages J, K, L: products, rotated offsets, rounded magnitudes.
    logic                  j_v_reg, k_v_reg, l_v_reg;
    logic signed [2*W:0]   j_xdx_reg, j_xdy_reg, j_ydx_reg, j_ydy_reg;
    logic                  j_tan_reg, k_tan_reg, l_tan_reg;
    logic                  j_fail_reg, k_fail_reg, l_fail_reg;
    logic [W-1:0]          j_ax_reg, j_ay_reg, k_ax_reg, k_ay_reg, l_ax_reg, l_ay_reg;
    logic [W:0]            j_d_reg, k_d_reg, l_d_reg;
    logic signed [2*W+1:0] k_n_reg [0:3];
    logic [2*W:0]          l_mag_reg [0:3];
    logic [3:0]            l_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
            l_v_reg <= 1'b0;
        end
        else
        begin
            j_v_reg <= s2_v;
            k_v_reg <= j_v_reg;
            l_v_reg <= k_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        j_xdx_reg  <= (2*W+1)'(s2_x) * (2*W+1)'(s2_dx);
        j_xdy_reg  <= (2*W+1)'(s2_x) * (2*W+1)'(s2_dy);
        j_ydx_reg  <= (2*W+1)'(s2_y) * (2*W+1)'(s2_dx);
        j_ydy_reg  <= (2*W+1)'(s2_y) * (2*W+1)'(s2_dy);
        j_tan_reg  <= (s2_root == '0);
        j_fail_reg <= s2_fail;
        j_ax_reg   <= s2_ax;
        j_ay_reg   <= s2_ay;
        j_d_reg    <= s2_d;

        k_n_reg[0] <= (2*W+2)'(j_xdx_reg) - (2*W+2)'(j_ydy_reg);
        k_n_reg[1] <= (2*W+2)'(j_xdy_reg) + (2*W+2)'(j_ydx_reg);
        k_n_reg[2] <= (2*W+2)'(j_xdx_reg) + (2*W+2)'(j_ydy_reg);
        k_n_reg[3] <= (2*W+2)'(j_xdy_reg) - (2*W+2)'(j_ydx_reg);
        k_tan_reg  <= j_tan_reg;
        k_fail_reg <= j_fail_reg;
        k_ax_reg   <= j_ax_reg;
        k_ay_reg   <= j_ay_reg;
        k_d_reg    <= j_d_reg;

        for (int n = 0; n < 4; n++)
        begin
            l_mag_reg[n] <= mag_of(k_n_reg[n]) + {{(W+1){1'b0}}, k_d_reg[W:1]};
            l_neg_reg[n] <= k_n_reg[n][2*W+1];
        end
        l_tan_reg  <= k_tan_reg;
        l_fail_reg <= k_fail_reg;
        l_ax_reg   <= k_ax_reg;
        l_ay_reg   <= k_ay_reg;
        l_d_reg    <= k_d_reg;
    end

    // Four divisions by the distance, one per output coordinate.
    localparam int P4W = W + W + 1 + 1 + 1;

    logic           q2_v [0:3];
    logic [2*W:0]   q2_quo [0:3];
    logic [P4W-1:0] q2_pay0;
    logic           q2_neg [1:3];
    logic [W-1:0]   q2_ax, q2_ay;
    logic           q2_tan, q2_fail, q2_neg0;

    ccis_div_chain #(
        .NW (2*W+1),
        .DW (W+1),
        .PW (P4W)
    ) u_fin_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l_v_reg),
        .in_num    (l_mag_reg[0]),
        .in_div    (l_d_reg),
        .in_pay    ({l_ax_reg, l_ay_reg, l_tan_reg, l_fail_reg, l_neg_reg[0]}),
        .out_valid (q2_v[0]),
        .out_quo   (q2_quo[0]),
        .out_pay   (q2_pay0)
    );

    assign {q2_ax, q2_ay, q2_tan, q2_fail, q2_neg0} = q2_pay0;

    for (genvar k = 1; k < 4; k++)
    begin : g_fin_div
        ccis_div_chain #(
            .NW (2*W+1),
            .DW (W+1),
            .PW (1)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (l_v_reg),
            .in_num    (l_mag_reg[k]),
            .in_div    (l_d_reg),
            .in_pay    (l_neg_reg[k]),
            .out_valid (q2_v[k]),
            .out_quo   (q2_quo[k]),
            .out_pay   (q2_neg[k])
        );
    end

    // Output stage: first point now, second point held for the next cycle.
    logic         fin_v;
    logic         point_valid_reg, point_valid_next;
    logic [W-1:0] point_x_reg, point_x_next;
    logic [W-1:0] point_y_reg, point_y_next;
    logic         last_reg, last_next;
    logic         pend_v_reg, pend_v_next;
    logic [W-1:0] pend_x_reg, pend_x_next;
    logic [W-1:0] pend_y_reg, pend_y_next;

    assign fin_v = q2_v[0] && q2_v[1] && q2_v[2] && q2_v[3];

    always_comb
    begin
        point_valid_next = 1'b0;
        point_x_next     = point_x_reg;
        point_y_next     = point_y_reg;
        last_next        = last_reg;
        pend_v_next      = 1'b0;
        pend_x_next      = place(q2_ax, q2_quo[2], q2_neg[2]);
        pend_y_next      = place(q2_ay, q2_quo[3], q2_neg[3]);
        if (fin_v && !q2_fail)
        begin
            point_valid_next = 1'b1;
            point_x_next     = place(q2_ax, q2_quo[0], q2_neg0);
            point_y_next     = place(q2_ay, q2_quo[1], q2_neg[1]);
            last_next        = q2_tan;
            pend_v_next      = !q2_tan;
        end
        else if (pend_v_reg)
        begin
            point_valid_next = 1'b1;
            point_x_next     = pend_x_reg;
            point_y_next     = pend_y_reg;
            last_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid_reg <= 1'b0;
            pend_v_reg      <= 1'b0;
        end
        else
        begin
            point_valid_reg <= point_valid_next;
            pend_v_reg      <= pend_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_x_reg <= point_x_next;
        point_y_reg <= point_y_next;
        last_reg    <= last_next;
        pend_x_reg  <= pend_x_next;
        pend_y_reg  <= pend_y_next;
    end

    assign point_valid = point_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign last_point  = last_reg;

endmodule

/* test/tb_circle_circle_intersection.sv */
`timescale 1ns / 100ps

module tb_circle_circle_intersection;
    import ccis_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int LATENCY = 6 * CW + 15;
    localparam int STALL_LIMIT = 4000;

    typedef logic signed [127:0] s128;
    typedef logic [127:0] u128;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } point_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [CW-1:0] center_a_x;
    logic [CW-1:0] center_a_y;
    logic [CW-1:0] center_b_x;
    logic [CW-1:0] center_b_y;
    logic [CW-2:0] radius_a;
    logic [CW-2:0] radius_b;
    logic          point_valid;
    logic [CW-1:0] point_x;
    logic [CW-1:0] point_y;
    logic          last_point;

    point_t pending_points[$];
    int     error_count = 0;
    int     items_sent = 0;
    int     points_seen = 0;
    int     idle_pct = 0;
    int     idle_cycles = 0;

    circle_circle_intersection #(.COORD_WIDTH(CW)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .center_a_x(center_a_x), .center_a_y(center_a_y),
        .center_b_x(center_b_x), .center_b_y(center_b_y),
        .radius_a(radius_a), .radius_b(radius_b),
        .point_valid(point_valid), .point_x(point_x), .point_y(point_y),
        .last_point(last_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor square root of a nonnegative 128-bit value.
    function automatic u128 floor_sqrt(input u128 n);
        u128 r;
        u128 c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (u128'(1) << b);
            if (c * c <= n)
                r = c;
        end
        return r;
    endfunction

    // Signed quotient rounded half away from zero, magnitude clamped to 2^62.
    function automatic s128 div_round(input s128 n, input s128 d);
        s128 m;
        s128 q;
        m = (n < 0) ? -n : n;
        q = (m + (d >>> 1)) / d;
        if (q > (s128'(1) <<< 62))
            q = s128'(1) <<< 62;
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [CW-1:0] saturate(input s128 v);
        s128 hi;
        s128 lo;
        hi = (s128'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[CW-1:0];
    endfunction

    // Append one expected point to the end of the queue.
    task automatic expect_point(input point_t p);
        pending_points = {pending_points, p};
    endtask

    // Work out the intersection points of one item and queue them.
    task automatic predict_intersections(input logic [CW-1:0] cax, input logic [CW-1:0] cay,
                                         input logic [CW-1:0] cbx, input logic [CW-1:0] cby,
                                         input logic [CW-2:0] rra, input logic [CW-2:0] rrb);
        s128    ax, ay, dx, dy, ra, rb, d2, d, num, x, xm, y;
        point_t p;
        ax = s128'($signed(cax));
        ay = s128'($signed(cay));
        dx = s128'($signed(cbx)) - ax;
        dy = s128'($signed(cby)) - ay;
        ra = s128'(rra);
        rb = s128'(rrb);
        if (dx == 0 && dy == 0)
            return;
        d2 = dx * dx + dy * dy;
        d = s128'(floor_sqrt(u128'(d2)));
        if (d2 - d * d > d)
            d = d + 1;
        num = ra * ra + d2 - rb * rb;
        x = div_round(num, 2 * d);
        xm = (x < 0) ? -x : x;
        if (xm > ra)
            return;
        y = s128'(floor_sqrt(u128'(ra * ra - xm * xm)));
        if (y == 0)
        begin
            p.x = saturate(ax + div_round(x * dx, d));
            p.y = saturate(ay + div_round(x * dy, d));
            p.last = 1'b1;
            expect_point(p);
            return;
        end
        p.x = saturate(ax + div_round(x * dx - y * dy, d));
        p.y = saturate(ay + div_round(x * dy + y * dx, d));
        p.last = 1'b0;
        expect_point(p);
        p.x = saturate(ax + div_round(x * dx + y * dy, d));
        p.y = saturate(ay + div_round(x * dy - y * dx, d));
        p.last = 1'b1;
        expect_point(p);
    endtask

    // Present one item, wait until it is taken, then predict its points.
    task automatic send_item(input logic [CW-1:0] cax, input logic [CW-1:0] cay,
                             input logic [CW-1:0] cbx, input logic [CW-1:0] cby,
                             input logic [CW-2:0] rra, input logic [CW-2:0] rrb);
        // Each cycle the sender idles with the chance set by idle_pct.
        if (idle_pct > 0)
        begin
            while ($urandom_range(99, 0) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        center_a_x <= cax;
        center_a_y <= cay;
        center_b_x <= cbx;
        center_b_y <= cby;
        radius_a <= rra;
        radius_b <= rrb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_intersections(cax, cay, cbx, cby, rra, rrb);
        items_sent++;
    endtask

    // Hold off the sender until every expected point has come out.
    task automatic drain_points();
        start <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Extremes of the fields and each kind of outcome.
    task automatic test_directed();
        localparam logic [CW-1:0] ONE = 32'h0001_0000;
        localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
        localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
        localparam logic [CW-2:0] MAXR = {(CW-1){1'b1}};
        // Coincident centers give nothing.
        send_item(ONE, ONE, ONE, ONE, ONE[CW-2:0], ONE[CW-2:0]);
        send_item('0, '0, '0, '0, '0, '0);
        // Circles far apart give nothing.
        send_item('0, '0, 32'h0100_0000, '0, ONE[CW-2:0], ONE[CW-2:0]);
        // One circle inside the other gives nothing.
        send_item('0, '0, ONE, '0, 31'h0010_0000, ONE[CW-2:0]);
        // Outer and inner tangent contacts give one point.
        send_item('0, '0, 32'h0002_0000, '0, ONE[CW-2:0], ONE[CW-2:0]);
        send_item('0, '0, '0, 32'h0001_0000, 31'h0002_0000, ONE[CW-2:0]);
        send_item(32'hFFFF_0000, '0, '0, '0, '0, ONE[CW-2:0]);
        // Two clean crossings, on both axes and diagonal.
        send_item('0, '0, 32'h0002_0000, '0, 31'h0002_0000, 31'h0002_0000);
        send_item('0, '0, '0, 32'hFFFE_0000, 31'h0002_0000, 31'h0002_0000);
        send_item(32'hFFFD_0000, 32'h0003_0000, 32'h0003_0000, 32'hFFFD_0000,
                  31'h0005_0000, 31'h0006_0000);
        // Extreme coordinates and radii, where saturation matters.
        send_item(MINC, MINC, MAXC, MAXC, MAXR, MAXR);
        send_item(MAXC, MAXC, MINC, MINC, MAXR, MAXR);
        send_item(MINC, MAXC, MAXC, MINC, MAXR, MAXR);
        send_item(MAXC, '0, MAXC - 1, '0, MAXR, MAXR);
        send_item(MINC, '0, MINC + 1, '0, MAXR, MAXR);
        send_item(MAXC, MAXC, MAXC, MAXC - ONE, MAXR, MAXR);
        send_item(MINC, MINC, MINC + ONE, MINC, '0, MAXR);
        send_item('1, '1, '0, '0, 31'd1, 31'd1);
        send_item('0, '0, 32'd1, 32'd1, 31'd1, 31'd1);
        drain_points();
    endtask

    // Random items, mostly circles that cross, with tangents and noise mixed in.
    task automatic test_random(input int count, input int pct);
        logic [CW-1:0] ax, ay, bx, by;
        logic [CW-2:0] ra, rb;
        int            mag, kind;
        real           sep, r1, lo, hi, r2;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99, 0);
            mag = $urandom_range(29, 2);
            ax = $urandom;
            ay = $urandom;
            if ($urandom_range(1, 0))
            begin
                ax = $signed(ax) >>> $urandom_range(CW - 2, 0);
                ay = $signed(ay) >>> $urandom_range(CW - 2, 0);
            end
            bx = ax + ($signed($urandom) >>> (CW - 1 - mag));
            by = ay + ($signed($urandom) >>> (CW - 1 - mag));
            if (kind < 20)
            begin
                ra = (CW-1)'($urandom);
                rb = (CW-1)'($urandom);
                if ($urandom_range(1, 0))
                begin
                    ra = ra >> $urandom_range(CW - 2, 0);
                    rb = rb >> $urandom_range(CW - 2, 0);
                end
            end
            else
            begin
                sep = $sqrt(($itor($signed(bx)) - $itor($signed(ax))) ** 2 +
                            ($itor($signed(by)) - $itor($signed(ay))) ** 2);
                r1 = sep * ($urandom_range(150, 5) / 100.0);
                lo = (sep > r1) ? sep - r1 : r1 - sep;
                hi = sep + r1;
                if (kind < 35)
                    r2 = ($urandom_range(1, 0)) ? lo : hi;
                else
                    r2 = lo + (hi - lo) * ($urandom_range(1000, 0) / 1000.0);
                if (r1 > 2147483647.0)
                    r1 = 2147483647.0;
                if (r2 > 2147483647.0)
                    r2 = 2147483647.0;
                ra = (CW-1)'($rtoi(r1));
                rb = (CW-1)'($rtoi(r2));
            end
            send_item(ax, ay, bx, by, ra, rb);
        end
        idle_pct = 0;
        drain_points();
    endtask

    // Compare every point with the oldest expectation.
    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && point_valid)
        begin
            points_seen++;
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point x=%h y=%h last=%b",
                         $time, point_x, point_y, last_point);
                error_count++;
            end
            else
            begin
                e = pending_points.pop_front();
                if (point_x !== e.x)
                begin
                    $display("%0t: point_x expected %h actual %h", $time, e.x, point_x);
                    error_count++;
                end
                if (point_y !== e.y)
                begin
                    $display("%0t: point_y expected %h actual %h", $time, e.y, point_y);
                    error_count++;
                end
                if (last_point !== e.last)
                begin
                    $display("%0t: last_point expected %b actual %b",
                             $time, e.last, last_point);
                    error_count++;
                end
            end
        end
    end

    // Stop the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n && !((start && !busy) || point_valid))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d points still expected", $time, pending_points.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        center_a_x = '0;
        center_a_y = '0;
        center_b_x = '0;
        center_b_y = '0;
        radius_a = '0;
        radius_b = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(180, 8);
        test_random(180, 77);
        test_random(180, 0);

        $display("Sent %0d items covering misses, tangents and crossings;", items_sent);
        $display("checked %0d points under three sender idle patterns.", points_seen);
        if (error_count == 0 && pending_points.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
